>>> rtl/core/pdc_pkg.sv
// shared types, constants and helpers for the palette dedup compactor
// no dependencies; used by every module under rtl/core

package pdc_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;

	localparam int        TIDX_W    = 9;
	localparam logic [8:0] TIDX_NONE = 9'd256;

	localparam int QUANT_MUL = 100;

	localparam logic [15:0] DIST_INIT    = 16'hFFFF;
	localparam int          CLOSEST_INIT = 1;

	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

	// where the placement color comes from in the cycle after the read
	typedef enum logic [1:0] {
		SRC_KEPT,
		SRC_RAW,
		SRC_FWD,
		SRC_ZERO
	} rd_src_t;

	// one result transaction
	typedef struct packed {
		logic       kind;
		logic       kept;
		logic [7:0] dest;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] size;
		logic       end_pass;
	} rec_t;

	// per-channel quantization (c * 100) >> 8, range 0..99
	function automatic logic [6:0] quant(input logic [7:0] c);
		logic [14:0] p;
		p = 15'(c) * 15'(QUANT_MUL);
		return p[14:8];
	endfunction

endpackage

>>> rtl/core/pdc_store.sv
// raw and kept color memories with one write and one registered read each
// depends on pdc_pkg (rd_src_t)

module pdc_store #(
	parameter int PALETTE_DEPTH = pdc_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             raw_we,
	input  logic [$clog2(PALETTE_DEPTH)-1:0] raw_waddr,
	input  logic                             kept_we,
	input  logic [$clog2(PALETTE_DEPTH)-1:0] kept_waddr,
	input  logic [23:0]                      wdata,
	input  logic                             rd_en,
	input  logic [$clog2(PALETTE_DEPTH)-1:0] rd_addr,
	input  pdc_pkg::rd_src_t                 rd_src,
	output logic [23:0]                      rd_color
);

	logic [23:0] raw_mem  [PALETTE_DEPTH];
	logic [23:0] kept_mem [PALETTE_DEPTH];

	logic [23:0]      raw_rdata_q;
	logic [23:0]      kept_rdata_q;
	logic [23:0]      fwd_q;
	pdc_pkg::rd_src_t src_q;

	always_ff @(posedge clk) begin
		if (raw_we) begin
			raw_mem[raw_waddr] <= wdata;
		end
		if (rd_en) begin
			raw_rdata_q <= raw_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (kept_we) begin
			kept_mem[kept_waddr] <= wdata;
		end
		if (rd_en) begin
			kept_rdata_q <= kept_mem[rd_addr];
		end
	end

	// bypass for a read that hits the entry written in the same cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			src_q <= rd_src;
			fwd_q <= wdata;
		end
	end

	always_comb begin
		case (src_q)
			pdc_pkg::SRC_KEPT: rd_color = kept_rdata_q;
			pdc_pkg::SRC_RAW:  rd_color = raw_rdata_q;
			pdc_pkg::SRC_FWD:  rd_color = fwd_q;
			default:           rd_color = '0;
		endcase
	end

endmodule

>>> rtl/core/pdc_dist.sv
// squared-distance pipeline and closest-entry tracker
// depends on pdc_pkg (reset constants)

module pdc_dist #(
	parameter int PALETTE_DEPTH = pdc_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [20:0]                      cur_q,
	input  logic [20:0]                      ref_q,
	input  logic                             upd_en,
	input  logic [$clog2(PALETTE_DEPTH)-1:0] upd_slot,
	input  logic                             pass_end,
	output logic [$clog2(PALETTE_DEPTH)-1:0] closest_slot
);

	localparam int AW = $clog2(PALETTE_DEPTH);

	logic signed [7:0] diff_c  [3];
	logic signed [7:0] diff_s1 [3];
	logic [13:0]       sq_c    [3];
	logic [13:0]       sq_s2   [3];
	logic [6:0]        mag;
	logic [15:0]       sum;
	logic [15:0]       dist_q;
	logic [AW-1:0]     slot_q;

	// channel differences at the input edge
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			diff_c[ch] = 8'({1'b0, cur_q[7*ch +: 7]}) - 8'({1'b0, ref_q[7*ch +: 7]});
		end
	end

	// magnitude squared per channel
	always_comb begin
		mag = '0;
		for (int ch = 0; ch < 3; ch++) begin
			mag = diff_s1[ch][7] ? 7'(-diff_s1[ch]) : 7'(diff_s1[ch]);
			sq_c[ch] = 14'(mag) * 14'(mag);
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= diff_c;
		sq_s2   <= sq_c;
	end

	assign sum = 16'(sq_s2[0]) + 16'(sq_s2[1]) + 16'(sq_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= pdc_pkg::DIST_INIT;
			slot_q <= AW'(pdc_pkg::CLOSEST_INIT);
		end else if (pass_end) begin
			dist_q <= pdc_pkg::DIST_INIT;
			slot_q <= AW'(pdc_pkg::CLOSEST_INIT);
		end else if (upd_en && (sum < dist_q)) begin
			dist_q <= sum;
			slot_q <= upd_slot;
		end
	end

	assign closest_slot = slot_q;

endmodule

>>> rtl/core/pdc_outq.sv
// result queue in front of the master stream port
// depends on pdc_pkg (rec_t, queue depth)

module pdc_outq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  pdc_pkg::rec_t                push_rec,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output pdc_pkg::rec_t                m_rec,
	output logic [pdc_pkg::OUTQ_CW-1:0] fill
);

	pdc_pkg::rec_t                 q_mem [pdc_pkg::OUTQ_DEPTH];
	logic [pdc_pkg::OUTQ_AW-1:0]   wptr_q;
	logic [pdc_pkg::OUTQ_AW-1:0]   rptr_q;
	logic [pdc_pkg::OUTQ_CW-1:0]   count_q;
	logic                          pop;

	assign m_tvalid = (count_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign m_rec    = q_mem[rptr_q];
	assign fill     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/palette_dedup_compactor.sv
// palette dedup compactor: a result passes stage 1, stage 2 and the result queue before
// it raises m_tvalid; a placement record is pushed in the cycle after its color's record
// throughput one color per cycle while the result queue has room; a final color that
// triggers a placement holds s_tready low for one cycle while its store read completes
// arst_n clears pass state, queue and register (transparent index 256); the raw
// store reads as zero above its fill mark, so no clearing pass is needed
// depends on pdc_pkg, pdc_store, pdc_dist, pdc_outq

module palette_dedup_compactor #(
	parameter int PALETTE_DEPTH = pdc_pkg::PALETTE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data,   // reserved transparency slot, 256 for none
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,       // red, green, blue
	input  logic        s_tlast,       // final_color
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,       // kept, dest_index, out_red, out_green, out_blue,
	                                   // palette_size, zero fill
	output logic        m_tuser,       // record_kind
	output logic        m_tlast        // end_of_pass
);

	localparam int AW   = $clog2(PALETTE_DEPTH);
	localparam int CW   = $clog2(PALETTE_DEPTH + 1);
	localparam int CMPW = (CW > pdc_pkg::TIDX_W) ? CW : pdc_pkg::TIDX_W;
	localparam int NW   = pdc_pkg::OUTQ_CW + 1;

	// configuration and pass state
	logic [8:0]    tidx_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] kept_count_q;
	logic [CW-1:0] hw_q;          // raw entries below this mark have been written
	logic [20:0]   lastq_q;       // quantized last kept color

	// placement waiting for its store read
	logic          pend_q;
	logic          pend_room_q;
	logic [CW-1:0] pend_size_q;
	logic [AW-1:0] pend_slot_q;

	// stage 1 and stage 2 records
	logic          v_s1, kind_s1, kept_s1, end_s1, dist_en_s1, room_s1;
	logic [AW-1:0] dest_s1;
	logic [CW-1:0] size_s1;
	logic [23:0]   color_s1;
	logic          v_s2, kind_s2, kept_s2, end_s2, dist_en_s2, room_s2;
	logic [AW-1:0] dest_s2;
	logic [CW-1:0] size_s2;
	logic [23:0]   color_s2;

	// input stage decode
	logic             acc;
	logic [23:0]      in_color;
	logic [20:0]      in_q;
	logic             in_range;
	logic             first;
	logic             keep;
	logic [CW-1:0]    count_after;
	logic [CMPW-1:0]  tidx_ext;
	logic             place;
	pdc_pkg::rd_src_t rd_src;
	logic [23:0]      rd_color;

	// output side
	logic [AW-1:0]                closest_slot;
	logic [AW-1:0]                slot_out;
	logic [CW-1:0]                size_out;
	pdc_pkg::rec_t                rec_s2;
	pdc_pkg::rec_t                m_rec;
	logic [pdc_pkg::OUTQ_CW-1:0] fill;
	logic [NW-1:0]                need;

	// accept only when the queue has room for everything in flight plus this
	// color and a possible placement
	assign need     = NW'(fill) + NW'(v_s1) + NW'(v_s2) + NW'(2);
	assign s_tready = !pend_q && (need <= NW'(pdc_pkg::OUTQ_DEPTH));
	assign acc      = s_tvalid && s_tready;

	assign in_color    = s_tdata;
	assign in_q        = {pdc_pkg::quant(s_tdata[23:16]), pdc_pkg::quant(s_tdata[15:8]),
	                      pdc_pkg::quant(s_tdata[7:0])};
	assign in_range    = pos_q < CW'(PALETTE_DEPTH);
	assign first       = (pos_q == '0);
	// a zero distance is exactly a match of all quantized channels
	assign keep        = in_range && (first || (in_q != lastq_q));
	assign count_after = kept_count_q + CW'(keep);
	assign tidx_ext    = CMPW'(tidx_q);
	assign place       = s_tlast && (tidx_ext < CMPW'(PALETTE_DEPTH));

	// source of the transparent color, with bypass of this cycle's writes
	always_comb begin
		if (tidx_ext < CMPW'(count_after)) begin
			if (keep && (tidx_ext == CMPW'(kept_count_q))) begin
				rd_src = pdc_pkg::SRC_FWD;
			end else begin
				rd_src = pdc_pkg::SRC_KEPT;
			end
		end else if (in_range && (tidx_ext == CMPW'(pos_q))) begin
			rd_src = pdc_pkg::SRC_FWD;
		end else if (tidx_ext < CMPW'(hw_q)) begin
			rd_src = pdc_pkg::SRC_RAW;
		end else begin
			rd_src = pdc_pkg::SRC_ZERO;
		end
	end

	pdc_store #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_store (
		.clk        (clk),
		.raw_we     (acc && in_range),
		.raw_waddr  (AW'(pos_q)),
		.kept_we    (acc && keep),
		.kept_waddr (AW'(kept_count_q)),
		.wdata      (in_color),
		.rd_en      (acc && place),
		.rd_addr    (AW'(tidx_q)),
		.rd_src     (rd_src),
		.rd_color   (rd_color)
	);

	pdc_dist #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_dist (
		.clk          (clk),
		.arst_n       (arst_n),
		.cur_q        (in_q),
		.ref_q        (lastq_q),
		.upd_en       (v_s2 && !kind_s2 && dist_en_s2),
		.upd_slot     (dest_s2 - AW'(1)),
		.pass_end     (v_s2 && end_s2),
		.closest_slot (closest_slot)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tidx_q       <= pdc_pkg::TIDX_NONE;
			pos_q        <= '0;
			kept_count_q <= '0;
			hw_q         <= '0;
			lastq_q      <= '0;
			pend_q       <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tidx_q <= cfg_wr_data;
			end
			if (acc) begin
				if (s_tlast) begin
					// pass over: back to start values, stores keep contents
					pos_q        <= '0;
					kept_count_q <= '0;
					lastq_q      <= '0;
				end else begin
					pos_q        <= pos_q + CW'(in_range);
					kept_count_q <= count_after;
					if (keep) begin
						lastq_q <= in_q;
					end
				end
				if (in_range && (pos_q >= hw_q)) begin
					hw_q <= pos_q + CW'(1);
				end
			end
			pend_q <= acc && place;
			v_s1   <= pend_q || acc;
			v_s2   <= v_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			pend_room_q <= count_after < CW'(PALETTE_DEPTH);
			pend_size_q <= count_after;
			pend_slot_q <= AW'(count_after);
		end
		if (pend_q) begin
			// transparency placement slips into the bubble after its color
			kind_s1    <= 1'b1;
			kept_s1    <= 1'b1;
			end_s1     <= 1'b1;
			dist_en_s1 <= 1'b0;
			room_s1    <= pend_room_q;
			dest_s1    <= pend_slot_q;
			size_s1    <= pend_size_q;
			color_s1   <= rd_color;
		end else begin
			kind_s1    <= 1'b0;
			kept_s1    <= keep;
			end_s1     <= s_tlast && !place;
			dist_en_s1 <= keep && !first;
			room_s1    <= 1'b0;
			dest_s1    <= keep ? AW'(kept_count_q) : '0;
			size_s1    <= count_after;
			color_s1   <= keep ? in_color : '0;
		end
		kind_s2    <= kind_s1;
		kept_s2    <= kept_s1;
		end_s2     <= end_s1;
		dist_en_s2 <= dist_en_s1;
		room_s2    <= room_s1;
		dest_s2    <= dest_s1;
		size_s2    <= size_s1;
		color_s2   <= color_s1;
	end

	// placement appends while there is room, else overwrites the closest entry
	assign slot_out = (kind_s2 && !room_s2) ? closest_slot : dest_s2;
	assign size_out = (kind_s2 && room_s2) ? (size_s2 + CW'(1)) : size_s2;

	always_comb begin
		rec_s2.kind     = kind_s2;
		rec_s2.kept     = kept_s2;
		rec_s2.dest     = 8'(slot_out);
		rec_s2.red      = color_s2[7:0];
		rec_s2.green    = color_s2[15:8];
		rec_s2.blue     = color_s2[23:16];
		rec_s2.size     = 9'(size_out);
		rec_s2.end_pass = end_s2;
	end

	pdc_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (v_s2),
		.push_rec (rec_s2),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_rec    (m_rec),
		.fill     (fill)
	);

	assign m_tdata = {6'b0, m_rec.size, m_rec.blue, m_rec.green, m_rec.red, m_rec.dest,
	                  m_rec.kept};
	assign m_tuser = m_rec.kind;
	assign m_tlast = m_rec.end_pass;

	// queue credit keeps every push in bounds
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (fill < pdc_pkg::OUTQ_CW'(pdc_pkg::OUTQ_DEPTH)))
		else $error("result queue overrun");

	// at most one kept entry per stored position
	a_count_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		kept_count_q <= pos_q)
		else $error("kept count ahead of input position");

	// a final color restarts the pass
	a_pass_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tlast) |=> ((pos_q == '0) && (kept_count_q == '0)))
		else $error("pass state not cleared after final color");

	// placement takes the bubble right behind its color
	a_place_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && place) |=> (!s_tready ##1 (v_s1 && kind_s1)))
		else $error("placement not inserted after final color");

endmodule

>>> tb/sv/palette_dedup_compactor_test.sv
// self-checking testbench for palette_dedup_compactor: directed and random palette passes
// with its own model of the compaction and transparency placement, random stalls on both sides
// depends on pdc_pkg and the palette_dedup_compactor rtl
`timescale 1ns / 100ps

module palette_dedup_compactor_test;

	localparam int DEPTH          = 256;
	localparam int NO_TRANSPARENT = 256;
	localparam int RANDOM_COLORS  = 1400;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 8;

	typedef struct packed {
		logic [23:0] color;   // blue, green, red from high to low
		logic        last;
	} color_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [8:0]  cfg_wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;     // red, green, blue
	logic        s_tlast = 1'b0;   // final_color
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;          // kept, dest_index, out_red, out_green, out_blue,
	                               // palette_size, zero fill
	logic        m_tuser;          // record_kind
	logic        m_tlast;          // end_of_pass

	palette_dedup_compactor #(.PALETTE_DEPTH(DEPTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	always #2 clk = ~clk;

	// colors waiting to be offered and palette writes waiting to come out
	color_item_t   pending_colors[$];
	pdc_pkg::rec_t palette_writes_q[$];
	color_item_t   next_item;
	bit            color_taken;
	int            queued_n, accepted_n;
	int            send_idle_pct, recv_stall_pct;
	bit            hold_request;
	int            hold_left;

	// model state of one compaction pass
	logic [23:0] raw_mem[DEPTH];
	logic [23:0] kept_mem[DEPTH];
	int          kept_n, in_pos, near_dist, near_slot;
	logic [23:0] last_kept;
	int          tidx = NO_TRANSPARENT;

	// run statistics
	int mismatch_n, checked_n, idle_cycles;
	int passes_n, dropped_n, ignored_n, placed_n, full_placed_n;

	function automatic int q100(input logic [7:0] c);
		return (int'(c) * 100) >> 8;
	endfunction

	function automatic int color_dist(input logic [23:0] a, input logic [23:0] b);
		int sum;
		int t;
		sum = 0;
		for (int ch = 0; ch < 3; ch++) begin
			t = q100(a[8*ch +: 8]) - q100(b[8*ch +: 8]);
			sum += t * t;
		end
		return sum;
	endfunction

	function automatic pdc_pkg::rec_t palette_write(input bit kind, input bit keep,
			input int dest, input logic [23:0] color, input bit end_pass);
		pdc_pkg::rec_t r;
		r.kind     = kind;
		r.kept     = keep;
		r.dest     = keep ? dest[7:0] : 8'd0;
		r.red      = keep ? color[7:0] : 8'd0;
		r.green    = keep ? color[15:8] : 8'd0;
		r.blue     = keep ? color[23:16] : 8'd0;
		r.size     = kept_n[8:0];
		r.end_pass = end_pass;
		return r;
	endfunction

	task automatic start_pass();
		kept_n    = 0;
		in_pos    = 0;
		last_kept = '0;
		near_dist = 16'hFFFF;
		near_slot = pdc_pkg::CLOSEST_INIT;
	endtask

	// advance the model by one accepted color and queue the palette writes it causes
	task automatic compact_color(input logic [23:0] color, input bit last);
		bit          keep;
		bit          place;
		int          dest, d, slot;
		logic [23:0] tc;
		keep  = 0;
		dest  = 0;
		place = last && tidx < DEPTH;
		if (in_pos < DEPTH) begin
			raw_mem[in_pos] = color;
			if (in_pos == 0) begin
				keep = 1;
			end else begin
				d = color_dist(last_kept, color);
				if (d != 0) begin
					keep = 1;
					if (d < near_dist) begin
						near_dist = d;
						near_slot = kept_n - 1;
					end
				end
			end
			if (keep && kept_n < DEPTH) begin
				dest           = kept_n;
				kept_mem[dest] = color;
				kept_n++;
				last_kept      = color;
			end else begin
				keep = 0;
				dropped_n++;
			end
			in_pos++;
		end else begin
			ignored_n++;
		end
		palette_writes_q.push_back(palette_write(0, keep, dest, color, last && !place));
		if (place) begin
			tc = (tidx < kept_n) ? kept_mem[tidx] : raw_mem[tidx];
			if (kept_n < DEPTH) begin
				slot = kept_n;
				kept_n++;
			end else begin
				slot = (near_slot < DEPTH) ? near_slot : 1;
				full_placed_n++;
			end
			kept_mem[slot] = tc;
			palette_writes_q.push_back(palette_write(1, 1, slot, tc, 1));
			placed_n++;
		end
		if (last) begin
			passes_n++;
			start_pass();
		end
	endtask

	// sender: a new transaction is offered only once the previous one was taken
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || color_taken)) begin
			color_taken = 0;
			if (pending_colors.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pending_colors.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= next_item.color;
				s_tlast  <= next_item.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 0;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// prediction on accepted colors, checking of accepted results, watchdog
	always @(posedge clk) begin
		pdc_pkg::rec_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				compact_color(s_tdata, s_tlast);
				accepted_n++;
				color_taken = 1;
			end
			if (m_tvalid && m_tready) begin
				got.kind     = m_tuser;
				got.kept     = m_tdata[0];
				got.dest     = m_tdata[8:1];
				got.red      = m_tdata[16:9];
				got.green    = m_tdata[24:17];
				got.blue     = m_tdata[32:25];
				got.size     = m_tdata[41:33];
				got.end_pass = m_tlast;
				checked_n++;
				if (palette_writes_q.size() == 0) begin
					mismatch_n++;
					if (mismatch_n <= 10)
						$display("unexpected result transaction: kind %0d kept %0d dest %0d",
							got.kind, got.kept, got.dest);
				end else begin
					want = palette_writes_q.pop_front();
					if (got !== want) begin
						mismatch_n++;
						if (mismatch_n <= 10) begin
							$display("mismatch on result %0d", checked_n);
							$display("  expected kind %0d kept %0d dest %0d rgb %02h %02h %02h size %0d end %0d",
								want.kind, want.kept, want.dest, want.red, want.green,
								want.blue, want.size, want.end_pass);
							$display("  actual   kind %0d kept %0d dest %0d rgb %02h %02h %02h size %0d end %0d",
								got.kind, got.kept, got.dest, got.red, got.green,
								got.blue, got.size, got.end_pass);
						end
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d cycles without a transaction", idle_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic queue_color(input logic [23:0] color, input bit last);
		color_item_t it;
		it.color = color;
		it.last  = last;
		pending_colors.push_back(it);
		queued_n++;
	endtask

	// same quantized color, low bit of each channel flipped where that changes nothing
	function automatic logic [23:0] quant_twin(input logic [23:0] c);
		logic [7:0] w;
		for (int ch = 0; ch < 3; ch++) begin
			w = c[8*ch +: 8] ^ 8'd1;
			if (q100(w) == q100(c[8*ch +: 8]))
				c[8*ch +: 8] = w;
		end
		return c;
	endfunction

	// one pass with random content and many duplicates
	task automatic queue_pass(input int len);
		logic [23:0] prev, c;
		int          roll;
		prev = '0;
		for (int i = 0; i < len; i++) begin
			roll = $urandom_range(99);
			if (i == 0 || roll >= 55)
				c = 24'($urandom);
			else if (roll < 30)
				c = prev;
			else if (roll < 45)
				c = quant_twin(prev);
			else
				c = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
			queue_color(c, i == len - 1);
			prev = c;
		end
	endtask

	// every color differs from the one before, so the kept store fills up
	task automatic queue_distinct_pass(input int len);
		logic [23:0] prev, c;
		prev = '0;
		for (int i = 0; i < len; i++) begin
			do
				c = 24'($urandom);
			while (i != 0 && color_dist(prev, c) == 0);
			queue_color(c, i == len - 1);
			prev = c;
		end
	endtask

	// block must be idle: all colors taken, all results out, pipeline settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (accepted_n != queued_n || palette_writes_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_transparent(input int value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value[8:0];
		tidx = value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		int phase, phase_start, roll;
		foreach (raw_mem[i]) begin
			raw_mem[i]  = '0;
			kept_mem[i] = '0;
		end
		start_pass();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset value of the register, exact and quantized duplicates,
		// extreme channel values, a pass of one color
		write_transparent(NO_TRANSPARENT);
		queue_color(24'h000000, 0);
		queue_color(24'h000000, 0);
		queue_color(24'hFFFFFF, 0);
		queue_color(24'hFEFEFE, 0);
		queue_color(24'h010203, 0);
		queue_color(24'h010203, 0);
		queue_color(24'hFF807F, 0);
		queue_color(24'h00FF01, 1);
		queue_color(24'h563412, 1);
		wait_drained();

		// placement of kept entry zero, appended
		write_transparent(0);
		queue_color(24'hCCBBAA, 0);
		queue_color(24'hCCBBAA, 0);
		queue_color(24'h302010, 1);
		wait_drained();

		// placement from a raw entry never written
		write_transparent(200);
		queue_color(24'hFF0000, 0);
		queue_color(24'h00FF00, 1);
		wait_drained();

		// overlong pass: store fills, colors beyond the depth ignored,
		// placement overwrites the closest entry
		write_transparent(DEPTH - 1);
		queue_distinct_pass(DEPTH + 14);
		wait_drained();

		// long pass with duplicates, index read from this pass's raw colors
		write_transparent(100);
		queue_pass(DEPTH + 2);
		wait_drained();

		// short pass reading a raw entry left by the earlier long passes
		write_transparent(250);
		queue_pass(5);
		wait_drained();

		// all duplicates, placement from raw entry one
		write_transparent(1);
		for (int i = 0; i < 5; i++)
			queue_color(24'h5A5A5A, i == 4);
		wait_drained();

		// random phases, cycling through the idling modes
		phase = 0;
		while (queued_n < RANDOM_COLORS) begin
			send_idle_pct  = (phase % 4 == 1) ? 81 : (phase % 4 == 3) ? 9 : 0;
			recv_stall_pct = (phase % 4 == 2) ? 81 : (phase % 4 == 3) ? 9 : 0;
			roll = $urandom_range(5);
			case (roll)
				0:       write_transparent(0);
				1:       write_transparent(NO_TRANSPARENT);
				2:       write_transparent(DEPTH - 1);
				3:       write_transparent($urandom_range(0, 15));
				4:       write_transparent($urandom_range(0, DEPTH - 1));
				default: write_transparent($urandom_range(0, NO_TRANSPARENT));
			endcase
			phase_start = queued_n;
			while (queued_n - phase_start < 80) begin
				if ($urandom_range(99) < 4)
					queue_pass($urandom_range(DEPTH, DEPTH + 6));
				else
					queue_pass($urandom_range(1, 20));
			end
			// output held off while the sender keeps offering
			if (phase == 0) begin
				@(posedge clk);
				hold_request = 1;
			end
			wait_drained();
			phase++;
		end

		repeat (20) @(negedge clk);
		if (palette_writes_q.size() != 0)
			mismatch_n++;
		$display("%0d colors in %0d passes, %0d dropped as duplicates, %0d beyond the depth",
			accepted_n, passes_n, dropped_n, ignored_n);
		$display("%0d transparency placements (%0d into a full palette), %0d results checked",
			placed_n, full_placed_n, checked_n);
		if (mismatch_n == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatch_n);
			$display("status: fail");
		end
		$finish;
	end

endmodule
